// File: hdl/mcme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcme_pkg: shared definitions for the MIDI channel message encoder
// Status and kind codes, message opcodes, scale limits and the record that
// travels with each request through the divider chain.
// ----------------------------------------------------------------------------
package mcme_pkg;

  // Default sample width
  localparam int SAMPLE_BITS_DEF = 24;

  // Quotient width: enough for the 14-bit pitch bend scale
  localparam int QW = 14;

  // Most bytes one request can produce (controller pulse)
  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = 3;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_READY  = 2'd1;
  localparam logic [1:0] ST_BAD_OPTION = 2'd2;
  localparam logic [1:0] ST_BAD_DATA   = 2'd3;

  // Endpoint kinds
  localparam logic [2:0] KIND_NOTE    = 3'd0;
  localparam logic [2:0] KIND_CONTROL = 3'd1;
  localparam logic [2:0] KIND_PROGRAM = 3'd2;
  localparam logic [2:0] KIND_PITCH   = 3'd3;
  localparam logic [2:0] KIND_PULSE   = 3'd4;

  // Signal kinds
  localparam logic [1:0] SIG_ANALOG = 2'd0;
  localparam logic [1:0] SIG_NOTE   = 2'd1;

  // Message opcodes (high nibble of the status byte)
  localparam logic [7:0] OP_NOTE_ON  = 8'h90;
  localparam logic [7:0] OP_NOTE_OFF = 8'h80;
  localparam logic [7:0] OP_CTRL     = 8'hB0;
  localparam logic [7:0] OP_PROGRAM  = 8'hC0;
  localparam logic [7:0] OP_BEND     = 8'hE0;
  localparam logic [7:0] DATA_MAX    = 8'h7F;

  // Full-scale values
  localparam logic [QW-1:0] FULL_7     = QW'(127);
  localparam logic [QW-1:0] FULL_PITCH = QW'(16383);

  // Per-request record carried alongside the division
  typedef struct packed {
    logic [1:0] status;   // status found before scaling
    logic [2:0] kind;
    logic [3:0] ch;
    logic [6:0] num;
    logic       note_on;
    logic       neg;      // sample was negative
    logic       ovf;      // quotient does not fit in QW bits
  } meta_t;

endpackage
`default_nettype wire

// File: hdl/midi_channel_message_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_channel_message_encoder_unit: MIDI channel voice message encoder
// Scales a sample to 7 or 14 bits through a chain of restoring division
// cells and emits the resulting MIDI message bytes, or one status result.
// ----------------------------------------------------------------------------
// A request passes the input, multiply and division setup registers and the
//   14 division cells, then the serializer register, before its first result.
// Throughput: one result per cycle at the output while out_ready is high; a
//   request yields 1 to 6 results.
// Requests enter every cycle while each yields one result and out_ready stays high.
// Reset: synchronous, clears all stage valid bits and port_open.
module midi_channel_message_encoder_unit #(
  parameter int SAMPLE_BITS = mcme_pkg::SAMPLE_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  // configuration write
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire                         cfg_data,
  // request channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [2:0]                   endpoint_kind,
  input  wire [3:0]                   midi_channel,
  input  wire [6:0]                   key_or_controller,
  input  wire [1:0]                   signal_kind,
  input  wire signed [SAMPLE_BITS-1:0] sample_value,
  input  wire [SAMPLE_BITS-2:0]       full_scale,
  input  wire                         note_on,
  // result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [7:0]                  message_byte,
  output logic                        message_end,
  output logic [1:0]                  status,
  output logic                        last
);
  import mcme_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int DIV_W = (SB - 1 > QW) ? SB - 1 : QW;
  localparam int NW    = SB + QW;

  logic port_open;

  // input stage
  logic             s0_vld;
  logic             s0_adv;
  meta_t            s0_meta;
  logic [SB-1:0]    s0_mag;
  logic [DIV_W-1:0] s0_div;
  meta_t            in_meta;
  logic [1:0]       pre_st;
  logic [QW-1:0]    in_full;
  logic [SB-1:0]    in_mag;

  // multiply stage
  logic             s1_vld;
  logic             s1_adv;
  meta_t            s1_meta;
  logic [NW-1:0]    s1_num;
  logic [DIV_W-1:0] s1_div;
  logic [QW-1:0]    s0_full;
  logic [NW-1:0]    prod;

  // division setup
  logic [DIV_W:0]   hi_ext;
  logic             hi_ovf;
  meta_t            setup_meta;

  // cell chain: index 0 is the setup stage, index QW the last cell
  logic             c_vld  [QW+1];
  logic             c_adv  [QW+1];
  meta_t            c_meta [QW+1];
  logic [DIV_W-1:0] c_div  [QW+1];
  logic [DIV_W-1:0] c_rem  [QW+1];
  logic [QW-1:0]    c_bits [QW+1];
  logic             ser_adv;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_open <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      port_open <= cfg_data;
    end
  end

  // Early checks on the incoming request
  always_comb begin
    priority if (!port_open) begin
      pre_st = ST_NOT_READY;
    end else if (endpoint_kind > KIND_PULSE) begin
      pre_st = ST_BAD_OPTION;
    end else if (endpoint_kind == KIND_NOTE) begin
      pre_st = (signal_kind == SIG_NOTE) ? ST_OK : ST_BAD_DATA;
    end else begin
      pre_st = (signal_kind == SIG_ANALOG) ? ST_OK : ST_BAD_DATA;
    end
  end

  assign in_full = (endpoint_kind == KIND_PITCH) ? FULL_PITCH : FULL_7;
  assign in_mag  = sample_value[SB-1] ? (~sample_value + SB'(1)) : sample_value;

  always_comb begin
    in_meta         = '0;
    in_meta.status  = pre_st;
    in_meta.kind    = endpoint_kind;
    in_meta.ch      = midi_channel;
    in_meta.num     = key_or_controller;
    in_meta.note_on = note_on;
    in_meta.neg     = sample_value[SB-1];
  end

  // Stage advance chain, from the output back to the input
  assign s1_adv   = !s1_vld || c_adv[0];
  assign s0_adv   = !s0_vld || s1_adv;
  assign in_ready = s0_adv;

  // Input stage: capture magnitude and divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (s0_adv) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s0_meta <= in_meta;
      s0_mag  <= in_mag;
      s0_div  <= (full_scale == '0) ? DIV_W'(in_full) : DIV_W'(full_scale);
    end
  end

  // Multiply stage: numerator = full scale * |sample|
  assign s0_full = (s0_meta.kind == KIND_PITCH) ? FULL_PITCH : FULL_7;
  assign prod    = {{QW{1'b0}}, s0_mag} * {{SB{1'b0}}, s0_full};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (s1_adv) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_meta <= s0_meta;
      s1_num  <= prod;
      s1_div  <= s0_div;
    end
  end

  // Setup stage: flag a quotient too wide, seed the partial remainder
  assign hi_ext = (DIV_W+1)'(s1_num[NW-1:QW]);
  assign hi_ovf = hi_ext >= {1'b0, s1_div};

  always_comb begin
    setup_meta     = s1_meta;
    setup_meta.ovf = hi_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld[0] <= 1'b0;
    end else if (c_adv[0]) begin
      c_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv[0]) begin
      c_meta[0] <= setup_meta;
      c_div[0]  <= s1_div;
      c_rem[0]  <= hi_ext[DIV_W-1:0];
      c_bits[0] <= s1_num[QW-1:0];
    end
  end

  // Division cells, one quotient bit each
  for (genvar k = 0; k < QW; k++) begin : g_cell
    logic dn_adv;

    // The last cell hands off to the serializer
    if (k == QW - 1) begin : g_tail
      assign dn_adv = ser_adv;
    end else begin : g_mid
      assign dn_adv = c_adv[k+2];
    end

    mcme_div_cell #(
      .DIV_W (DIV_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_vld  (c_vld[k]),
      .up_adv  (c_adv[k+1]),
      .dn_adv  (dn_adv),
      .meta_in (c_meta[k]),
      .div_in  (c_div[k]),
      .rem_in  (c_rem[k]),
      .bits_in (c_bits[k]),
      .vld     (c_vld[k+1]),
      .meta    (c_meta[k+1]),
      .div     (c_div[k+1]),
      .rem     (c_rem[k+1]),
      .bits    (c_bits[k+1])
    );
  end

  assign c_adv[0] = !c_vld[0] || c_adv[1];

  // Message build and byte output
  mcme_serializer u_ser (
    .clk          (clk),
    .rst          (rst),
    .up_vld       (c_vld[QW]),
    .up_adv       (ser_adv),
    .meta_in      (c_meta[QW]),
    .quo          (c_bits[QW]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .message_byte (message_byte),
    .message_end  (message_end),
    .status       (status),
    .last         (last)
  );

  // A failed request yields one empty, final result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && !message_end && message_byte == 8'h00)
    else $error("status result is not a single empty final result");

  // The final result of a good request closes a message
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK && last |-> message_end)
    else $error("final byte does not end a message");

  // Requests are refused only while both the input and multiply stages hold one
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s0_vld && s1_vld)
    else $error("request refused with room in the front stages");

  // A message that follows another in the same request opens with a status byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && message_end && !last |=> !out_valid || message_byte[7])
    else $error("message does not open with a status byte");

endmodule
`default_nettype wire

// File: hdl/mcme_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcme_div_cell: one restoring division step
// Shifts the next numerator bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in from the right.
// ----------------------------------------------------------------------------
module mcme_div_cell #(
  parameter int DIV_W = 23
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          up_vld,
  output logic                         up_adv,
  input  wire                          dn_adv,
  input  mcme_pkg::meta_t              meta_in,
  input  wire [DIV_W-1:0]              div_in,
  input  wire [DIV_W-1:0]              rem_in,
  input  wire [mcme_pkg::QW-1:0]       bits_in,
  output logic                         vld,
  output mcme_pkg::meta_t              meta,
  output logic [DIV_W-1:0]             div,
  output logic [DIV_W-1:0]             rem,
  output logic [mcme_pkg::QW-1:0]      bits
);
  import mcme_pkg::*;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  // Take a new request when empty or when the neighbor takes ours
  assign up_adv = !vld || dn_adv;

  // Trial subtract
  assign trial = {rem_in, bits_in[QW-1]};
  assign diff  = trial - {1'b0, div_in};
  assign ge    = trial >= {1'b0, div_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_adv) begin
      vld <= up_vld;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (up_adv) begin
      meta <= meta_in;
      div  <= div_in;
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      bits <= {bits_in[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// File: hdl/mcme_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcme_serializer: message builder and byte output stage
// Checks the scaled value, builds the bytes of the request's messages and
// shifts them out one byte per accepted result.
// ----------------------------------------------------------------------------
module mcme_serializer (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      up_vld,
  output logic                     up_adv,
  input  mcme_pkg::meta_t          meta_in,
  input  wire [mcme_pkg::QW-1:0]   quo,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [7:0]               message_byte,
  output logic                     message_end,
  output logic [1:0]               status,
  output logic                     last
);
  import mcme_pkg::*;

  logic                 vld;
  logic [CNT_W-1:0]     cnt;
  logic [1:0]           st_q;
  logic [7:0]           byte_q [MAX_BYTES];
  logic [MAX_BYTES-1:0] end_q;

  logic [QW-1:0]        full;
  logic [1:0]           fst;
  logic [7:0]           ld_byte [MAX_BYTES];
  logic [MAX_BYTES-1:0] ld_end;
  logic [CNT_W-1:0]     ld_cnt;
  logic [7:0]           chan;
  logic [7:0]           q_lo;
  logic [7:0]           q_hi;

  // Load the next request when empty or when the final byte leaves
  assign up_adv = !vld || (out_ready && cnt == CNT_W'(1));

  // Range check and message build
  always_comb begin
    full = (meta_in.kind == KIND_PITCH) ? FULL_PITCH : FULL_7;
    fst  = meta_in.status;
    if (fst == ST_OK) begin
      if (meta_in.ovf) begin
        fst = ST_BAD_DATA;
      end else if (quo != '0 && (meta_in.neg || quo > full)) begin
        fst = ST_BAD_DATA;
      end
    end
    chan = {4'h0, meta_in.ch};
    q_lo = {1'b0, quo[6:0]};
    q_hi = {1'b0, quo[13:7]};
    for (int i = 0; i < MAX_BYTES; i++) begin
      ld_byte[i] = 8'h00;
    end
    ld_end = '0;
    ld_cnt = CNT_W'(1);
    if (fst == ST_OK) begin
      unique case (meta_in.kind)
        KIND_NOTE: begin
          ld_byte[0] = (meta_in.note_on ? OP_NOTE_ON : OP_NOTE_OFF) | chan;
          ld_byte[1] = {1'b0, meta_in.num};
          ld_byte[2] = q_lo;
          ld_end[2]  = 1'b1;
          ld_cnt     = CNT_W'(3);
        end
        KIND_CONTROL: begin
          ld_byte[0] = OP_CTRL | chan;
          ld_byte[1] = {1'b0, meta_in.num};
          ld_byte[2] = q_lo;
          ld_end[2]  = 1'b1;
          ld_cnt     = CNT_W'(3);
        end
        KIND_PROGRAM: begin
          ld_byte[0] = OP_PROGRAM | chan;
          ld_byte[1] = q_lo;
          ld_end[1]  = 1'b1;
          ld_cnt     = CNT_W'(2);
        end
        KIND_PITCH: begin
          ld_byte[0] = OP_BEND | chan;
          ld_byte[1] = q_lo;
          ld_byte[2] = q_hi;
          ld_end[2]  = 1'b1;
          ld_cnt     = CNT_W'(3);
        end
        default: begin
          // controller pulse: value high, then value low
          ld_byte[0] = OP_CTRL | chan;
          ld_byte[1] = q_lo;
          ld_byte[2] = DATA_MAX;
          ld_byte[3] = OP_CTRL | chan;
          ld_byte[4] = q_lo;
          ld_byte[5] = 8'h00;
          ld_end[2]  = 1'b1;
          ld_end[5]  = 1'b1;
          ld_cnt     = CNT_W'(6);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_adv) begin
      vld <= up_vld;
    end
  end

  // Load a new request or shift out one byte
  always_ff @(posedge clk) begin
    if (up_adv) begin
      byte_q <= ld_byte;
      end_q  <= ld_end;
      cnt    <= ld_cnt;
      st_q   <= fst;
    end else if (vld && out_ready) begin
      for (int i = 0; i < MAX_BYTES - 1; i++) begin
        byte_q[i] <= byte_q[i+1];
      end
      byte_q[MAX_BYTES-1] <= 8'h00;
      end_q <= end_q >> 1;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  assign out_valid    = vld;
  assign message_byte = byte_q[0];
  assign message_end  = end_q[0];
  assign status       = st_q;
  assign last         = (cnt == CNT_W'(1));

endmodule
`default_nettype wire
